FILE: rtl/core/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg: shared types, widths and helpers for the fuzzy centroid controller
// Holds the fixed-point widths, register codes and the single-step division
// helpers used by the membership and centroid divider pipelines.
// ----------------------------------------------------------------------------
package fcc_pkg;

  // Base widths
  localparam int DATA_WIDTH       = 16;
  localparam int DEGREE_FRAC_BITS = 16;
  localparam int DEG_W            = DEGREE_FRAC_BITS + 1;

  // Datapath widths (d = degree, w = edge width)
  localparam int DW_W    = DEG_W + DATA_WIDTH;                 // d*w
  localparam int POS_W   = DATA_WIDTH + DEGREE_FRAC_BITS + 1;  // position in 1/ONE units
  localparam int BP_W    = DEG_W + DW_W;                       // d*d*w
  localparam int SQ_W    = 2 * DW_W;                           // (d*w)^2
  localparam int CUB_W   = SQ_W + DEG_W;                       // d^3*w^2
  localparam int E3_W    = DATA_WIDTH + 2;                     // 3*end point
  localparam int LIN_W   = BP_W + E3_W;
  localparam int TA_W    = BP_W + 2;
  localparam int DL_W    = DEG_W + POS_W;
  localparam int LS_W    = 2 * POS_W + 1;
  localparam int D3_W    = DEG_W + 2;
  localparam int AREA_W  = 3 * DEGREE_FRAC_BITS + DATA_WIDTH + 6;
  localparam int MOM_W   = AREA_W + DATA_WIDTH + 2;

  // Register file
  localparam int REG2_W  = 2 * DATA_WIDTH;
  localparam int REG3_W  = 3 * DATA_WIDTH;
  localparam int APB_DW  = 64;
  localparam int ADDR_W  = 6;
  localparam int REG_LSB = 3;

  // Pipeline shape
  localparam int NUM_MF    = 3;
  localparam int NUM_SLP   = 4;
  localparam int NUM_RECT  = 3;
  localparam int DIV_STEPS = DEG_W;
  localparam int CTR_STEPS = DATA_WIDTH;
  localparam int PIPE_LAT  = DIV_STEPS + CTR_STEPS + 9;

  localparam logic [DEG_W-1:0] ONE_D = DEG_W'(1) << DEGREE_FRAC_BITS;

  // Slope order: short falling, medium rising, medium falling, long rising
  localparam int SLP_MF [NUM_SLP] = '{0, 1, 1, 2};
  localparam logic [NUM_SLP-1:0] SLP_RISE = 4'b1010;

  typedef enum logic [2:0] {
    REG_LOW_SHOULDER,
    REG_MID_TRIANGLE,
    REG_HIGH_SHOULDER,
    REG_SHORT_SET,
    REG_MEDIUM_SET,
    REG_LONG_SET
  } reg_idx_t;

  typedef logic [NUM_MF-1:0][DEG_W-1:0] degs_t;

  // One membership divider lane
  typedef struct packed {
    logic                  use_div;
    logic [DEG_W-1:0]      cval;
    logic [DATA_WIDTH-1:0] den;
    logic [DATA_WIDTH:0]   rem;
    logic [DEG_W-1:0]      q;
  } mdiv_t;

  // Centroid divider stage
  typedef struct packed {
    logic [MOM_W-1:0]      mom;
    logic [AREA_W-1:0]     area;
    logic                  none;
    logic [DATA_WIDTH-1:0] q;
    degs_t                 degs;
  } cdiv_t;

  // One restoring step of (num * ONE) / den, num <= den
  function automatic mdiv_t mdiv_step(mdiv_t s, logic first);
    logic [DATA_WIDTH:0] t;
    logic                ge;
    mdiv_t               r;
    t  = first ? s.rem : {s.rem[DATA_WIDTH-1:0], 1'b0};
    ge = (t >= {1'b0, s.den});
    r  = s;
    r.rem = ge ? (t - {1'b0, s.den}) : t;
    r.q   = {s.q[DEG_W-2:0], ge};
    return r;
  endfunction

  // One restoring step of moment / area at quotient bit sh
  function automatic cdiv_t cdiv_step(cdiv_t s, int unsigned sh);
    logic [MOM_W-1:0] dv;
    logic             ge;
    cdiv_t            r;
    dv = MOM_W'(s.area) << sh;
    ge = (s.mom >= dv);
    r  = s;
    if (ge) begin
      r.mom = s.mom - dv;
    end
    r.q = {s.q[DATA_WIDTH-2:0], ge};
    return r;
  endfunction

endpackage

FILE: rtl/core/fuzzy_centroid_controller.sv
// ----------------------------------------------------------------------------
// fuzzy_centroid_controller: pipelined Mamdani controller, centroid output
// Three input memberships clip three output sets; clipped areas and first
// moments are summed in closed form and divided for the crisp value.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+---------------------------
//  command   | in        | start high, busy low       | sensor_value
//  result    | out       | done strobe, one cycle     | crisp_out, degree_low/mid/
//            |           |                            | high, no_rule_fired
//  config    | in/out    | APB, write at access phase | paddr, pwdata, prdata
//
//  One sample enters per cycle outside reset; each result passes the 17-step
//  membership divider, stages A to F, the 16-step centroid divider and the
//  result registers, one restoring step per divider stage.
//  Reset is synchronous: it clears the valid bits and the configuration
//  registers, and holds busy high. The receiver cannot stall, so the pipeline
//  always advances and busy is low outside reset.
//
module fuzzy_centroid_controller (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [fcc_pkg::DATA_WIDTH-1:0]  sensor_value,
  output logic                            done,
  output logic [fcc_pkg::DATA_WIDTH-1:0]  crisp_out,
  output logic [fcc_pkg::DEG_W-1:0]       degree_low,
  output logic [fcc_pkg::DEG_W-1:0]       degree_mid,
  output logic [fcc_pkg::DEG_W-1:0]       degree_high,
  output logic                            no_rule_fired,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fcc_pkg::ADDR_W-1:0]      paddr,
  input  logic [fcc_pkg::APB_DW-1:0]      pwdata,
  output logic [fcc_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import fcc_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int FB = DEGREE_FRAC_BITS;

  // Configuration registers
  logic [REG2_W-1:0] low_pts;
  logic [REG3_W-1:0] mid_pts;
  logic [REG2_W-1:0] high_pts;
  logic [REG3_W-1:0] short_pts;
  logic [REG3_W-1:0] medium_pts;
  logic [REG3_W-1:0] long_pts;

  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:REG_LSB]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign busy    = rst;

  // Write a register at the access phase; ignore unknown addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      low_pts    <= '0;
      mid_pts    <= '0;
      high_pts   <= '0;
      short_pts  <= '0;
      medium_pts <= '0;
      long_pts   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LOW_SHOULDER:  low_pts    <= pwdata[REG2_W-1:0];
        REG_MID_TRIANGLE:  mid_pts    <= pwdata[REG3_W-1:0];
        REG_HIGH_SHOULDER: high_pts   <= pwdata[REG2_W-1:0];
        REG_SHORT_SET:     short_pts  <= pwdata[REG3_W-1:0];
        REG_MEDIUM_SET:    medium_pts <= pwdata[REG3_W-1:0];
        REG_LONG_SET:      long_pts   <= pwdata[REG3_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_idx)
      REG_LOW_SHOULDER:  prdata = APB_DW'(low_pts);
      REG_MID_TRIANGLE:  prdata = APB_DW'(mid_pts);
      REG_HIGH_SHOULDER: prdata = APB_DW'(high_pts);
      REG_SHORT_SET:     prdata = APB_DW'(short_pts);
      REG_MEDIUM_SET:    prdata = APB_DW'(medium_pts);
      REG_LONG_SET:      prdata = APB_DW'(long_pts);
      default:           prdata = '0;
    endcase
  end

  // Unpack breakpoints
  logic [DW-1:0] lo_s, lo_e, mi_l, mi_p, mi_r, hi_s, hi_e;
  logic [DW-1:0] sa0, sa1, sa2, me0, me1, me2, lg0, lg1, lg2;

  assign lo_s = low_pts[DW-1:0];
  assign lo_e = low_pts[2*DW-1:DW];
  assign mi_l = mid_pts[DW-1:0];
  assign mi_p = mid_pts[2*DW-1:DW];
  assign mi_r = mid_pts[3*DW-1:2*DW];
  assign hi_s = high_pts[DW-1:0];
  assign hi_e = high_pts[2*DW-1:DW];
  assign sa0  = short_pts[DW-1:0];
  assign sa1  = short_pts[2*DW-1:DW];
  assign sa2  = short_pts[3*DW-1:2*DW];
  assign me0  = medium_pts[DW-1:0];
  assign me1  = medium_pts[2*DW-1:DW];
  assign me2  = medium_pts[3*DW-1:2*DW];
  assign lg0  = long_pts[DW-1:0];
  assign lg1  = long_pts[2*DW-1:DW];
  assign lg2  = long_pts[3*DW-1:2*DW];

  // Output slope widths (inverted edges count as zero) and outer points
  logic [NUM_SLP-1:0][DW-1:0]   slp_w, slp_e;
  logic [NUM_SLP-1:0][E3_W-1:0] slp_e3;

  assign slp_w[0] = (sa2 > sa1) ? (sa2 - sa1) : '0;
  assign slp_w[1] = (me1 > me0) ? (me1 - me0) : '0;
  assign slp_w[2] = (me2 > me1) ? (me2 - me1) : '0;
  assign slp_w[3] = (lg1 > lg0) ? (lg1 - lg0) : '0;
  assign slp_e[0] = sa2;
  assign slp_e[1] = me0;
  assign slp_e[2] = me2;
  assign slp_e[3] = lg0;

  always_comb begin
    for (int i = 0; i < NUM_SLP; i++) begin
      slp_e3[i] = E3_W'(slp_e[i]) * E3_W'(3);
    end
  end

  // Valid bits travel alongside every stage
  logic [PIPE_LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], start && !busy};
    end
  end

  // Classify the sample against each input set
  mdiv_t [NUM_MF-1:0] mset;

  always_comb begin
    mset = '0;
    // low shoulder
    if (sensor_value < lo_s) begin
      mset[0].cval = ONE_D;
    end else if (sensor_value <= lo_e) begin
      if (lo_e == lo_s) begin
        mset[0].cval = ONE_D;
      end else begin
        mset[0].use_div = 1'b1;
        mset[0].rem     = {1'b0, lo_e - sensor_value};
        mset[0].den     = lo_e - lo_s;
      end
    end
    // middle triangle
    if (sensor_value >= mi_l) begin
      if (sensor_value <= mi_p) begin
        if (mi_p == mi_l) begin
          mset[1].cval = ONE_D;
        end else begin
          mset[1].use_div = 1'b1;
          mset[1].rem     = {1'b0, sensor_value - mi_l};
          mset[1].den     = mi_p - mi_l;
        end
      end else if (sensor_value <= mi_r) begin
        mset[1].use_div = 1'b1;
        mset[1].rem     = {1'b0, mi_r - sensor_value};
        mset[1].den     = mi_r - mi_p;
      end
    end
    // high shoulder
    if (sensor_value >= hi_s) begin
      if (sensor_value <= hi_e) begin
        if (hi_e == hi_s) begin
          mset[2].cval = ONE_D;
        end else begin
          mset[2].use_div = 1'b1;
          mset[2].rem     = {1'b0, sensor_value - hi_s};
          mset[2].den     = hi_e - hi_s;
        end
      end else begin
        mset[2].cval = ONE_D;
      end
    end
  end

  // Membership dividers: one quotient bit per stage
  mdiv_t [NUM_MF-1:0] dv [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    dv[0] <= mset;
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int i = 0; i < NUM_MF; i++) begin
        dv[k+1][i] <= mdiv_step(dv[k][i], k == 0);
      end
    end
  end

  degs_t degc;

  always_comb begin
    for (int i = 0; i < NUM_MF; i++) begin
      degc[i] = dv[DIV_STEPS][i].use_div ? dv[DIV_STEPS][i].q : dv[DIV_STEPS][i].cval;
    end
  end

  // Stage A: d*w for each slope
  degs_t                      a_dg;
  logic [NUM_SLP-1:0][DW_W-1:0] a_dw;

  always_ff @(posedge clk) begin
    a_dg <= degc;
    for (int i = 0; i < NUM_SLP; i++) begin
      a_dw[i] <= DW_W'(degc[SLP_MF[i]]) * DW_W'(slp_w[i]);
    end
  end

  // Rectangle bounds in 1/ONE units
  logic [NUM_RECT-1:0][POS_W-1:0] rp, rq;

  assign rp[0] = {1'b0, sa0, {FB{1'b0}}};
  assign rq[0] = {1'b0, sa2, {FB{1'b0}}} - POS_W'(a_dw[0]);
  assign rp[1] = {1'b0, me0, {FB{1'b0}}} + POS_W'(a_dw[1]);
  assign rq[1] = {1'b0, me2, {FB{1'b0}}} - POS_W'(a_dw[2]);
  assign rp[2] = {1'b0, lg0, {FB{1'b0}}} + POS_W'(a_dw[3]);
  assign rq[2] = {1'b0, lg2, {FB{1'b0}}};

  // Stage B: d^2 w, (d w)^2, rectangle length and sum
  degs_t                           b_dg;
  logic [NUM_SLP-1:0][BP_W-1:0]    b_bp;
  logic [NUM_SLP-1:0][SQ_W-1:0]    b_sq;
  logic [NUM_RECT-1:0]             b_on;
  logic [NUM_RECT-1:0][POS_W-1:0]  b_len;
  logic [NUM_RECT-1:0][POS_W:0]    b_sum;

  always_ff @(posedge clk) begin
    b_dg <= a_dg;
    for (int i = 0; i < NUM_SLP; i++) begin
      b_bp[i] <= BP_W'(a_dg[SLP_MF[i]]) * BP_W'(a_dw[i]);
      b_sq[i] <= SQ_W'(a_dw[i]) * SQ_W'(a_dw[i]);
    end
    for (int r = 0; r < NUM_RECT; r++) begin
      b_on[r]  <= rq[r] > rp[r];
      b_len[r] <= rq[r] - rp[r];
      b_sum[r] <= (POS_W+1)'(rq[r]) + (POS_W+1)'(rp[r]);
    end
  end

  // Stage C: cubic and linear slope terms, rectangle products
  degs_t                          c_dg;
  logic [NUM_SLP-1:0][CUB_W-1:0]  c_cub;
  logic [NUM_SLP-1:0][LIN_W-1:0]  c_lin;
  logic [NUM_SLP-1:0][TA_W-1:0]   c_ta;
  logic [NUM_RECT-1:0]            c_on;
  logic [NUM_RECT-1:0][DL_W-1:0]  c_dl;
  logic [NUM_RECT-1:0][LS_W-1:0]  c_ls;
  logic [NUM_RECT-1:0][D3_W-1:0]  c_d3;

  always_ff @(posedge clk) begin
    c_dg <= b_dg;
    c_on <= b_on;
    for (int i = 0; i < NUM_SLP; i++) begin
      c_cub[i] <= CUB_W'(b_sq[i]) * CUB_W'(b_dg[SLP_MF[i]]);
      c_lin[i] <= LIN_W'(b_bp[i]) * LIN_W'(slp_e3[i]);
      c_ta[i]  <= TA_W'(b_bp[i]) * TA_W'(3);
    end
    for (int r = 0; r < NUM_RECT; r++) begin
      c_dl[r] <= DL_W'(b_dg[r]) * DL_W'(b_len[r]);
      c_ls[r] <= LS_W'(b_len[r]) * LS_W'(b_sum[r]);
      c_d3[r] <= D3_W'(b_dg[r]) * D3_W'(3);
    end
  end

  // Stage D: scaled area and moment of every piece
  degs_t                            d_dg;
  logic [NUM_SLP-1:0][AREA_W-1:0]   d_ta;
  logic [NUM_SLP-1:0][MOM_W-1:0]    d_tm;
  logic [NUM_RECT-1:0][AREA_W-1:0]  d_ra;
  logic [NUM_RECT-1:0][MOM_W-1:0]   d_rm;

  always_ff @(posedge clk) begin
    d_dg <= c_dg;
    for (int i = 0; i < NUM_SLP; i++) begin
      d_ta[i] <= AREA_W'(c_ta[i]) << FB;
      if (SLP_RISE[i]) begin
        d_tm[i] <= (MOM_W'(c_lin[i]) << FB) + (MOM_W'(c_cub[i]) << 1);
      end else begin
        d_tm[i] <= (MOM_W'(c_lin[i]) << FB) - (MOM_W'(c_cub[i]) << 1);
      end
    end
    for (int r = 0; r < NUM_RECT; r++) begin
      d_ra[r] <= c_on[r] ? ((AREA_W'(c_dl[r]) * AREA_W'(6)) << FB) : '0;
      d_rm[r] <= c_on[r] ? (MOM_W'(c_ls[r]) * MOM_W'(c_d3[r])) : '0;
    end
  end

  // Stage E: per output set sums
  degs_t                          e_dg;
  logic [NUM_MF-1:0][AREA_W-1:0]  e_a;
  logic [NUM_MF-1:0][MOM_W-1:0]   e_m;

  always_ff @(posedge clk) begin
    e_dg   <= d_dg;
    e_a[0] <= d_ta[0] + d_ra[0];
    e_a[1] <= d_ta[1] + d_ta[2] + d_ra[1];
    e_a[2] <= d_ta[3] + d_ra[2];
    e_m[0] <= d_tm[0] + d_rm[0];
    e_m[1] <= d_tm[1] + d_tm[2] + d_rm[1];
    e_m[2] <= d_tm[3] + d_rm[2];
  end

  // Stage F: totals
  degs_t             f_dg;
  logic [AREA_W-1:0] f_area;
  logic [MOM_W-1:0]  f_mom;

  always_ff @(posedge clk) begin
    f_dg   <= e_dg;
    f_area <= e_a[0] + e_a[1] + e_a[2];
    f_mom  <= e_m[0] + e_m[1] + e_m[2];
  end

  // Centroid divider: flag empty area, then one quotient bit per stage
  cdiv_t cs [CTR_STEPS+1];
  cdiv_t cinit;

  always_comb begin
    cinit.mom  = f_mom;
    cinit.area = f_area;
    cinit.none = (f_area == '0);
    cinit.q    = '0;
    cinit.degs = f_dg;
  end

  always_ff @(posedge clk) begin
    cs[0] <= cinit;
    for (int k = 0; k < CTR_STEPS; k++) begin
      cs[k+1] <= cdiv_step(cs[k], CTR_STEPS - 1 - k);
    end
  end

  // Drive the result registers
  always_ff @(posedge clk) begin
    crisp_out     <= cs[CTR_STEPS].none ? '0 : cs[CTR_STEPS].q;
    degree_low    <= cs[CTR_STEPS].degs[0];
    degree_mid    <= cs[CTR_STEPS].degs[1];
    degree_high   <= cs[CTR_STEPS].degs[2];
    no_rule_fired <= cs[CTR_STEPS].none;
  end

  assign done = vld[PIPE_LAT-1];

  // Checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##(PIPE_LAT-1) done)
    else $error("result strobe missing after fixed latency");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && no_rule_fired) |-> (crisp_out == '0))
    else $error("crisp output not zero with no rule fired");

  a_deg_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (degree_low <= ONE_D && degree_mid <= ONE_D && degree_high <= ONE_D))
    else $error("membership degree above one");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (vld[PIPE_LAT-2] && !cs[CTR_STEPS].none) |->
      (cs[CTR_STEPS].mom < MOM_W'(cs[CTR_STEPS].area)))
    else $error("centroid divider remainder not below area");

endmodule
